@@ hdl/pfe_pkg.sv @@
// Shared types and constants of the postfix expression evaluator.
// Depends on nothing; every other file refers to it by scoped names.
package pfe_pkg;

    // Operand stack geometry
    localparam int STACK_DEPTH = 64;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Datapath and divider
    localparam int DATA_W     = 32;
    localparam int DIV_STEP_W = $clog2(DATA_W);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_DIVZ  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        t_status                  status;
    } t_out_item;

    // One command per input beat that has work for the back end
    typedef struct packed {
        logic              do_push;
        logic [DATA_W-1:0] num;
        logic              do_op;
        t_op               op;
        logic              do_end;
    } t_cmd;

endpackage

@@ hdl/pfe_front.sv @@
// Front end: accepts characters, builds decimal numbers, classifies them into commands.
// Depends on pfe_pkg; feeds pfe_cmdq.
module pfe_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  pfe_pkg::t_in_item i_item,
    input  logic            i_q_full,
    output logic            o_q_push,
    output pfe_pkg::t_cmd   o_q_cmd
);

    logic [pfe_pkg::DATA_W-1:0] r_acc, n_acc;
    logic                       r_in_num, n_in_num;

    logic                       accept;
    logic                       is_digit;
    logic                       is_op;
    logic [7:0]                 digit_off;
    logic [pfe_pkg::DATA_W-1:0] acc_digit;
    pfe_pkg::t_op               op_code;

    assign o_full = i_q_full;
    assign accept = i_push & ~i_q_full;

    // Classify the character
    always_comb begin
        is_digit  = (i_item.char_code >= pfe_pkg::CH_ZERO) &&
                    (i_item.char_code <= pfe_pkg::CH_NINE);
        is_op     = (i_item.char_code == pfe_pkg::CH_PLUS)  ||
                    (i_item.char_code == pfe_pkg::CH_MINUS) ||
                    (i_item.char_code == pfe_pkg::CH_STAR)  ||
                    (i_item.char_code == pfe_pkg::CH_SLASH);
        digit_off = i_item.char_code - pfe_pkg::CH_ZERO;
        // acc * 10 + digit, wrapping
        acc_digit = (r_acc << 3) + (r_acc << 1) +
                    {{(pfe_pkg::DATA_W-4){1'b0}}, digit_off[3:0]};
        priority if (i_item.char_code == pfe_pkg::CH_MINUS) begin
            op_code = pfe_pkg::OP_SUB;
        end else if (i_item.char_code == pfe_pkg::CH_STAR) begin
            op_code = pfe_pkg::OP_MUL;
        end else if (i_item.char_code == pfe_pkg::CH_SLASH) begin
            op_code = pfe_pkg::OP_DIV;
        end else begin
            op_code = pfe_pkg::OP_ADD;
        end
    end

    // Build the command: flush a pending number, then operator, then end
    always_comb begin
        o_q_cmd.do_push = is_digit ? i_item.is_last : r_in_num;
        o_q_cmd.num     = is_digit ? acc_digit : r_acc;
        o_q_cmd.do_op   = is_op;
        o_q_cmd.op      = op_code;
        o_q_cmd.do_end  = i_item.is_last;
        o_q_push        = accept &&
                          (o_q_cmd.do_push || o_q_cmd.do_op || o_q_cmd.do_end);
    end

    // Advance the number accumulator
    always_comb begin
        n_acc    = r_acc;
        n_in_num = r_in_num;
        if (accept) begin
            if (is_digit && !i_item.is_last) begin
                n_acc    = acc_digit;
                n_in_num = 1'b1;
            end else begin
                n_acc    = '0;
                n_in_num = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_in_num <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_in_num <= n_in_num;
        end
    end

endmodule

@@ hdl/pfe_cmdq.sv @@
// Short command queue that decouples the front end from the back end.
// Depends on pfe_pkg.
module pfe_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pfe_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pfe_pkg::t_cmd o_head
);

    pfe_pkg::t_cmd                  r_mem [pfe_pkg::CMDQ_DEPTH];
    logic [pfe_pkg::CMDQ_PTR_W-1:0] r_wp, n_wp;
    logic [pfe_pkg::CMDQ_PTR_W-1:0] r_rp, n_rp;
    logic [pfe_pkg::CMDQ_CNT_W-1:0] r_cnt, n_cnt;
    logic                           do_wr;
    logic                           do_rd;

    localparam logic [pfe_pkg::CMDQ_PTR_W-1:0] LastPtr =
        pfe_pkg::CMDQ_PTR_W'(pfe_pkg::CMDQ_DEPTH - 1);

    assign o_full  = (r_cnt == pfe_pkg::CMDQ_CNT_W'(pfe_pkg::CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];
    assign do_wr   = i_push & ~o_full;
    assign do_rd   = i_pop & ~o_empty;

    // Advance pointers and fill count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_wr) begin
            n_wp = (r_wp == LastPtr) ? '0 : r_wp + 1'b1;
        end
        if (do_rd) begin
            n_rp = (r_rp == LastPtr) ? '0 : r_rp + 1'b1;
        end
        if (do_wr && !do_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_rd && !do_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the incoming command
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

@@ hdl/pfe_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on pfe_pkg; used by pfe_back.
module pfe_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pfe_pkg::DATA_W-1:0] i_dividend,
    input  logic [pfe_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [pfe_pkg::DATA_W-1:0] o_quotient
);

    localparam int W = pfe_pkg::DATA_W;

    typedef enum logic [2:0] {
        D_IDLE = 3'b001,
        D_RUN  = 3'b010,
        D_DONE = 3'b100
    } t_dstate;

    t_dstate                       r_state, n_state;
    logic [W-1:0]                  r_quo, n_quo;
    logic [W-1:0]                  r_rem, n_rem;
    logic [W-1:0]                  r_den, n_den;
    logic                          r_neg, n_neg;
    logic [pfe_pkg::DIV_STEP_W-1:0] r_step, n_step;

    logic [W:0]   shifted;
    logic [W+1:0] trial;

    assign o_done     = (r_state == D_DONE);
    assign o_quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

    // One restoring step: shift in the next dividend bit, try to subtract
    always_comb begin
        shifted = {r_rem, r_quo[W-1]};
        trial   = {1'b0, shifted} - {2'b00, r_den};
    end

    always_comb begin
        n_state = r_state;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        n_neg   = r_neg;
        n_step  = r_step;
        unique case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_quo   = i_dividend[W-1] ? (~i_dividend + 1'b1) : i_dividend;
                    n_den   = i_divisor[W-1] ? (~i_divisor + 1'b1) : i_divisor;
                    n_neg   = i_dividend[W-1] ^ i_divisor[W-1];
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = D_RUN;
                end
            end
            D_RUN: begin
                if (!trial[W+1]) begin
                    n_rem = trial[W-1:0];
                    n_quo = {r_quo[W-2:0], 1'b1};
                end else begin
                    n_rem = shifted[W-1:0];
                    n_quo = {r_quo[W-2:0], 1'b0};
                end
                n_step = r_step + 1'b1;
                if (r_step == pfe_pkg::DIV_STEP_W'(W - 1)) begin
                    n_state = D_DONE;
                end
            end
            D_DONE: begin
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_neg  <= n_neg;
        r_step <= n_step;
    end

endmodule

@@ hdl/pfe_back.sv @@
// Back end: operand stack, arithmetic, error tracking and the result register.
// Depends on pfe_pkg and pfe_div.
module pfe_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  pfe_pkg::t_cmd      i_q_head,
    output logic               o_q_pop,
    input  logic               i_res_pop,
    output logic               o_res_empty,
    output pfe_pkg::t_out_item o_result
);

    localparam int W = pfe_pkg::DATA_W;

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_PUSH = 6'b000010,
        B_RDA  = 6'b000100,
        B_EXEC = 6'b001000,
        B_DIV  = 6'b010000,
        B_END  = 6'b100000
    } t_bstate;

    // Operand stack memory
    logic [W-1:0] r_stack [pfe_pkg::STACK_DEPTH];

    t_bstate                     r_state, n_state;
    pfe_pkg::t_cmd               r_cmd, n_cmd;
    logic [pfe_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    pfe_pkg::t_status            r_err, n_err;
    logic [W-1:0]                r_top, n_top;
    logic [W-1:0]                r_rd;
    pfe_pkg::t_out_item          r_res, n_res;
    logic                        r_res_vld, n_res_vld;

    logic                        we;
    logic [pfe_pkg::PTR_W-1:0]   waddr;
    logic [W-1:0]                wdata;
    logic                        stack_full;
    logic [pfe_pkg::CNT_W-1:0]   below_idx;
    logic [pfe_pkg::PTR_W-1:0]   below_ptr;
    logic [W-1:0]                alu;
    logic                        div_start;
    logic                        div_done;
    logic [W-1:0]                div_quo;
    t_bstate                     after_op;

    assign o_res_empty = ~r_res_vld;
    assign o_result    = r_res;

    assign stack_full = (r_cnt == pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH));
    assign below_idx  = r_cnt - pfe_pkg::CNT_W'(2);
    assign below_ptr  = below_idx[pfe_pkg::PTR_W-1:0];
    assign after_op   = r_cmd.do_end ? B_END : B_IDLE;
    assign div_start  = (r_state == B_EXEC) && (r_cmd.op == pfe_pkg::OP_DIV) &&
                        (r_top != '0);

    // Add, subtract, multiply on (below, top)
    always_comb begin
        unique case (r_cmd.op)
            pfe_pkg::OP_ADD: alu = r_rd + r_top;
            pfe_pkg::OP_SUB: alu = r_rd - r_top;
            pfe_pkg::OP_MUL: alu = r_rd * r_top;
            default:         alu = '0;
        endcase
    end

    pfe_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_rd),
        .i_divisor  (r_top),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Sequence each command: push, operator, end of expression
    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_cnt     = r_cnt;
        n_err     = r_err;
        n_top     = r_top;
        n_res     = r_res;
        n_res_vld = r_res_vld & ~i_res_pop;
        o_q_pop   = 1'b0;
        we        = 1'b0;
        waddr     = r_cnt[pfe_pkg::PTR_W-1:0];
        wdata     = r_cmd.num;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    n_state = B_PUSH;
                end
            end
            B_PUSH: begin
                if (r_cmd.do_push) begin
                    if (stack_full) begin
                        if (r_err == pfe_pkg::ST_OK) begin
                            n_err = pfe_pkg::ST_OVER;
                        end
                    end else begin
                        we    = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                        n_top = r_cmd.num;
                    end
                end
                if (r_cmd.do_op) begin
                    n_state = B_RDA;
                end else begin
                    n_state = after_op;
                end
            end
            B_RDA: begin
                // the below-top operand is read this cycle
                if (r_cnt < pfe_pkg::CNT_W'(2)) begin
                    if (r_err == pfe_pkg::ST_OK) begin
                        n_err = pfe_pkg::ST_UNDER;
                    end
                    n_state = after_op;
                end else begin
                    n_state = B_EXEC;
                end
            end
            B_EXEC: begin
                if (r_cmd.op != pfe_pkg::OP_DIV) begin
                    we      = 1'b1;
                    waddr   = below_ptr;
                    wdata   = alu;
                    n_top   = alu;
                    n_cnt   = r_cnt - 1'b1;
                    n_state = after_op;
                end else if (r_top == '0) begin
                    if (r_err == pfe_pkg::ST_OK) begin
                        n_err = pfe_pkg::ST_DIVZ;
                    end
                    we      = 1'b1;
                    waddr   = below_ptr;
                    wdata   = '0;
                    n_top   = '0;
                    n_cnt   = r_cnt - 1'b1;
                    n_state = after_op;
                end else begin
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                if (div_done) begin
                    we      = 1'b1;
                    waddr   = below_ptr;
                    wdata   = div_quo;
                    n_top   = div_quo;
                    n_cnt   = r_cnt - 1'b1;
                    n_state = after_op;
                end
            end
            B_END: begin
                // hold until the result register is free
                if (!r_res_vld || i_res_pop) begin
                    if (r_cnt == '0) begin
                        n_res.value  = '0;
                        n_res.status = (r_err == pfe_pkg::ST_OK) ?
                                       pfe_pkg::ST_UNDER : r_err;
                    end else begin
                        n_res.value  = r_top;
                        n_res.status = r_err;
                    end
                    n_res_vld = 1'b1;
                    n_cnt     = '0;
                    n_err     = pfe_pkg::ST_OK;
                    n_state   = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_cnt     <= '0;
            r_err     <= pfe_pkg::ST_OK;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_err     <= n_err;
            r_res_vld <= n_res_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_top <= n_top;
        r_res <= n_res;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_stack[waddr] <= wdata;
        end
        r_rd <= r_stack[below_ptr];
    end

endmodule

@@ hdl/postfix_evaluator.sv @@
// Postfix expression evaluator: top level joining front end, command queue and back end.
// Depends on pfe_pkg, pfe_front, pfe_cmdq, pfe_back.
//
// Input channel: one ASCII character per beat (char_code, is_last), taken when
// push is high and full is low. Result channel: one beat (value, status) per
// expression, shown while empty is low and taken when pop is high.
// The front end takes a character and hands a command to a
// two-entry queue; digits that do not end the expression make no command.
// For each command the back end fetches it, runs the push step (even
// with no number), for an operator reads the below-top operand and
// executes it, waiting on the bit-serial divider for / by a nonzero value,
// and loads the result when the command ends the expression; the worst
// case is a final /. The result follows once earlier commands have drained.
// When the receiver stalls, the result holds in its output register; the back
// end waits at the next end of expression while the front keeps filling the
// queue until full rises.
// Reset (synchronous, active low) empties the queue and the stack and clears
// the error; the stack memory needs no clearing pass.
module postfix_evaluator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  pfe_pkg::t_in_item  i_item,
    output logic               empty,
    input  logic               pop,
    output pfe_pkg::t_out_item o_result
);

    logic          q_push;
    pfe_pkg::t_cmd q_cmd;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    pfe_pkg::t_cmd q_head;

    pfe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd)
    );

    pfe_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    pfe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_head    (q_head),
        .o_q_pop     (q_pop),
        .i_res_pop   (pop),
        .o_res_empty (empty),
        .o_result    (o_result)
    );

endmodule

@@ hdl/pfe_checker.sv @@
// Port-level checker for the postfix expression evaluator, bound to the top level.
// Depends on pfe_pkg and postfix_evaluator.
module pfe_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               push,
    input logic               full,
    input pfe_pkg::t_in_item  i_item,
    input logic               empty,
    input logic               pop,
    input pfe_pkg::t_out_item o_result
);

    logic [2:0] r_pending, n_pending;
    logic       in_last;
    logic       out_beat;

    assign in_last  = push && !full && i_item.is_last;
    assign out_beat = pop && !empty;

    // Track expressions ended but not yet delivered
    always_comb begin
        n_pending = r_pending;
        if (in_last && !out_beat) begin
            n_pending = r_pending + 1'b1;
        end else if (out_beat && !in_last) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("stalled result changed or vanished");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_pending != 3'd0))
        else $error("result without an ended expression");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_beat && (r_pending == 3'd1) && !in_last) |=> empty)
        else $error("extra result after the last one was taken");

endmodule

bind postfix_evaluator pfe_checker u_pfe_checker (.*);
